// File: design/qrm_pkg.sv
// Shared types, constants and a rounding helper for the quaternion to rotation matrix block.
package qrm_pkg;

   localparam int COMP_W   = 16;
   localparam int M_W      = 30;
   localparam int R_W      = 18;
   localparam int T_W      = 48;
   localparam int P_W      = 63;
   localparam int CAND_W   = 67;
   localparam int SQRT_STEPS = 18;
   localparam int LATENCY  = 26;
   localparam logic [15:0] Q14_ONE = 16'h4000;

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic                zero;
      logic [3:0][15:0]    q;
      logic [4:0]          sh;
      logic [M_W-1:0]      m;
      logic [R_W-1:0]      r;
      logic [T_W-1:0]      t;
      logic [P_W-1:0]      p;
   } sqrt_bus_type;

   function automatic logic [15:0] round_sat14(input logic signed [36:0] v);
      logic [36:0] mag;
      logic [23:0] rnd;
      mag = v[36] ? 37'(-v) : 37'(v);
      rnd = 24'((mag + 37'd8192) >> 14);
      if (!v[36] && rnd > 24'd32767) return 16'h7fff;
      if (v[36] && rnd > 24'd32768) return 16'h8000;
      return v[36] ? 16'(-rnd) : 16'(rnd);
   endfunction

endpackage

// File: design/qrm_front.sv
// Front end: input capture, squared length and block normalization of the length.
module qrm_front import qrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  comp_type     quat_x,
   input  comp_type     quat_y,
   input  comp_type     quat_z,
   input  comp_type     quat_w,
   output logic         out_valid,
   output sqrt_bus_type out_bus
);

   logic [2:0]       valid_ff;
   logic [3:0][15:0] q1_ff;
   logic [3:0][15:0] q2_ff;
   logic [3:0][15:0] q3_ff;
   logic [3:0][30:0] sq_ff;
   logic [32:0]      s_ff;
   logic [32:0]      s_in;
   logic [3:0][30:0] sq_in;
   logic [5:0]       msb;
   logic signed [6:0] kval;
   logic [6:0]       kmag;
   logic [5:0]       amt;
   sqrt_bus_type     bus_in;
   sqrt_bus_type     bus_ff;
   logic             valid_out_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = 31'($signed(q1_ff[i]) * $signed(q1_ff[i]));
      end
      s_in = 33'(sq_ff[0]) + 33'(sq_ff[1]) + 33'(sq_ff[2]) + 33'(sq_ff[3]);
   end

   always_comb begin
      msb = '0;
      for (int i = 0; i < 33; i++) begin
         if (s_ff[i]) msb = 6'(i);
      end
      kval = ($signed({1'b0, msb}) - 7'sd28) >>> 1;
      kmag = kval[6] ? 7'(-kval) : 7'(kval);
      amt = 6'(kmag << 1);
      bus_in.zero = (s_ff == '0);
      bus_in.q = q3_ff;
      bus_in.sh = 5'(7'sd17 + kval);
      bus_in.m = kval[6] ? M_W'(s_ff << amt) : M_W'(s_ff >> amt);
      bus_in.r = '0;
      bus_in.t = '0;
      bus_in.p = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         valid_out_ff <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
         valid_out_ff <= valid_ff[2];
      end
      q1_ff <= {quat_w, quat_z, quat_y, quat_x};
      q2_ff <= q1_ff;
      q3_ff <= q2_ff;
      sq_ff <= sq_in;
      s_ff <= s_in;
      bus_ff <= bus_in;
   end

   assign out_valid = valid_out_ff;
   assign out_bus = bus_ff;

endmodule

// File: design/qrm_isqrt_stage.sv
// One bit step of the inverse square root search, testing r*r*M against 2^62.
module qrm_isqrt_stage import qrm_pkg::*; #(
   parameter int BIT_POS = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  sqrt_bus_type in_bus,
   output logic         out_valid,
   output sqrt_bus_type out_bus
);

   logic [CAND_W-1:0] cand;
   logic              take;
   sqrt_bus_type      bus_in;
   sqrt_bus_type      bus_ff;
   logic              valid_ff;

   always_comb begin
      cand = {4'b0, in_bus.p}
           + ({19'b0, in_bus.t} << (BIT_POS + 1))
           + ({37'b0, in_bus.m} << (2 * BIT_POS));
      take = (cand <= (CAND_W'(1) << 62));
      bus_in = in_bus;
      if (take) begin
         bus_in.r = in_bus.r | (R_W'(1) << BIT_POS);
         bus_in.p = cand[P_W-1:0];
         bus_in.t = in_bus.t + (T_W'(in_bus.m) << BIT_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      bus_ff <= bus_in;
   end

   assign out_valid = valid_ff;
   assign out_bus = bus_ff;

endmodule

// File: design/qrm_back.sv
// Back end: component normalization, pair products and matrix entries with saturation.
module qrm_back import qrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  sqrt_bus_type in_bus,
   output logic         out_valid,
   output logic [8:0][15:0] out_m,
   output logic         out_zero
);

   logic [2:0]              valid_ff;
   logic                    valid_out_ff;
   logic [3:0]              zero_ff;
   logic [4:0]              sh_ff;
   logic signed [34:0]      prod_ff [4];
   logic signed [34:0]      prod_in [4];
   logic signed [16:0]      n_ff [4];
   logic signed [16:0]      n_in [4];
   logic signed [33:0]      pp_ff [9];
   logic signed [33:0]      pp_in [9];
   logic [8:0][15:0]        m_ff;
   logic [8:0][15:0]        m_in;
   logic [34:0]             mag;
   logic [34:0]             rnd;
   logic signed [36:0]      one;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = 35'($signed(in_bus.q[i]) * $signed({1'b0, in_bus.r}));
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag = prod_ff[i][34] ? 35'(-prod_ff[i]) : 35'(prod_ff[i]);
         rnd = (mag + (35'(1) << (sh_ff - 5'd1))) >> sh_ff;
         n_in[i] = prod_ff[i][34] ? -17'(rnd) : 17'(rnd);
      end
   end

   always_comb begin
      pp_in[0] = n_ff[0] * n_ff[0];
      pp_in[1] = n_ff[1] * n_ff[1];
      pp_in[2] = n_ff[2] * n_ff[2];
      pp_in[3] = n_ff[0] * n_ff[1];
      pp_in[4] = n_ff[0] * n_ff[2];
      pp_in[5] = n_ff[1] * n_ff[2];
      pp_in[6] = n_ff[0] * n_ff[3];
      pp_in[7] = n_ff[1] * n_ff[3];
      pp_in[8] = n_ff[2] * n_ff[3];
   end

   always_comb begin
      one = 37'sd268435456;
      m_in[0] = round_sat14(one - ((37'(pp_ff[1]) + 37'(pp_ff[2])) <<< 1));
      m_in[1] = round_sat14((37'(pp_ff[3]) + 37'(pp_ff[8])) <<< 1);
      m_in[2] = round_sat14((37'(pp_ff[4]) - 37'(pp_ff[7])) <<< 1);
      m_in[3] = round_sat14((37'(pp_ff[3]) - 37'(pp_ff[8])) <<< 1);
      m_in[4] = round_sat14(one - ((37'(pp_ff[0]) + 37'(pp_ff[2])) <<< 1));
      m_in[5] = round_sat14((37'(pp_ff[5]) + 37'(pp_ff[6])) <<< 1);
      m_in[6] = round_sat14((37'(pp_ff[4]) + 37'(pp_ff[7])) <<< 1);
      m_in[7] = round_sat14((37'(pp_ff[5]) - 37'(pp_ff[6])) <<< 1);
      m_in[8] = round_sat14(one - ((37'(pp_ff[0]) + 37'(pp_ff[1])) <<< 1));
      if (zero_ff[2]) begin
         m_in = '0;
         m_in[0] = Q14_ONE;
         m_in[4] = Q14_ONE;
         m_in[8] = Q14_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         valid_out_ff <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
         valid_out_ff <= valid_ff[2];
      end
      zero_ff <= {zero_ff[2:0], in_bus.zero};
      sh_ff <= in_bus.sh;
      prod_ff <= prod_in;
      n_ff <= n_in;
      pp_ff <= pp_in;
      m_ff <= m_in;
   end

   assign out_valid = valid_out_ff;
   assign out_m = m_ff;
   assign out_zero = zero_ff[3];

endmodule

// File: design/quaternion_to_rotation_matrix_top.sv
// Top level of the quaternion to 3x3 rotation matrix converter.
//
// A quaternion transfer is taken at each rising edge where start is high and
// busy is low. The block never raises busy, so a new quaternion may enter in
// every cycle and the throughput is one matrix per clock.
// Each quaternion gives exactly one result transfer: rsp_valid is high for one
// cycle with the nine matrix entries and the zero-length flag. Between the
// input transfer and the result lie four front stages (capture, squares,
// sum, normalization), eighteen inverse square root bit stages and four back
// stages (scaling, rounding, pair products, entries with saturation).
// The receiver cannot hold results off, so nothing is ever stalled.
// A synchronous reset clears all valid bits; items in flight are dropped and
// no result appears until new quaternions are accepted.
module quaternion_to_rotation_matrix_top import qrm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  comp_type req_quat_x,
   input  comp_type req_quat_y,
   input  comp_type req_quat_z,
   input  comp_type req_quat_w,
   output logic     rsp_valid,
   output comp_type rsp_m_r0c0,
   output comp_type rsp_m_r0c1,
   output comp_type rsp_m_r0c2,
   output comp_type rsp_m_r1c0,
   output comp_type rsp_m_r1c1,
   output comp_type rsp_m_r1c2,
   output comp_type rsp_m_r2c0,
   output comp_type rsp_m_r2c1,
   output comp_type rsp_m_r2c2,
   output logic     rsp_zero_length
);

   sqrt_bus_type     stage_bus [SQRT_STEPS+1];
   logic             stage_valid [SQRT_STEPS+1];
   logic [8:0][15:0] m;

   assign busy = 1'b0;

   qrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .quat_w    (req_quat_w),
      .out_valid (stage_valid[0]),
      .out_bus   (stage_bus[0])
   );

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      qrm_isqrt_stage #(.BIT_POS(SQRT_STEPS - 1 - g)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_bus    (stage_bus[g]),
         .out_valid (stage_valid[g+1]),
         .out_bus   (stage_bus[g+1])
      );
   end

   qrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[SQRT_STEPS]),
      .in_bus    (stage_bus[SQRT_STEPS]),
      .out_valid (rsp_valid),
      .out_m     (m),
      .out_zero  (rsp_zero_length)
   );

   assign rsp_m_r0c0 = m[0];
   assign rsp_m_r0c1 = m[1];
   assign rsp_m_r0c2 = m[2];
   assign rsp_m_r1c0 = m[3];
   assign rsp_m_r1c1 = m[4];
   assign rsp_m_r1c2 = m[5];
   assign rsp_m_r2c0 = m[6];
   assign rsp_m_r2c1 = m[7];
   assign rsp_m_r2c2 = m[8];

endmodule

// File: design/qrm_checker.sv
// Port-level checker for the quaternion to rotation matrix converter, with its bind.
module qrm_checker import qrm_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     start,
   input logic     busy,
   input comp_type req_quat_x,
   input comp_type req_quat_y,
   input comp_type req_quat_z,
   input comp_type req_quat_w,
   input logic     rsp_valid,
   input comp_type rsp_m_r0c0,
   input comp_type rsp_m_r0c1,
   input comp_type rsp_m_r1c1,
   input comp_type rsp_m_r2c2,
   input logic     rsp_zero_length
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy was raised");

   a_result_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching input transfer");

   a_zero_gives_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_quat_x == 16'sd0 && req_quat_y == 16'sd0 &&
                         req_quat_z == 16'sd0 && req_quat_w == 16'sd0, LATENCY)
      |-> rsp_zero_length)
      else $error("zero quaternion did not raise the flag");

   a_zero_gives_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
      rsp_m_r0c0 == Q14_ONE && rsp_m_r1c1 == Q14_ONE && rsp_m_r2c2 == Q14_ONE &&
      rsp_m_r0c1 == 16'sd0)
      else $error("zero-length result is not the identity");

endmodule

bind quaternion_to_rotation_matrix_top qrm_checker u_qrm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_quat_x      (req_quat_x),
   .req_quat_y      (req_quat_y),
   .req_quat_z      (req_quat_z),
   .req_quat_w      (req_quat_w),
   .rsp_valid       (rsp_valid),
   .rsp_m_r0c0      (rsp_m_r0c0),
   .rsp_m_r0c1      (rsp_m_r0c1),
   .rsp_m_r1c1      (rsp_m_r1c1),
   .rsp_m_r2c2      (rsp_m_r2c2),
   .rsp_zero_length (rsp_zero_length)
);
